FILE: rtl/nbbv_pkg.sv
// Shared types and constants of the naive Bayes vote classifier.
// No dependencies; the front end, back end and top level import this package.
package nbbv_pkg;

  // Default sizes and fixed field widths
  localparam int MAX_ATTRS_DEF = 16;
  localparam int COST_BITS_DEF = 16;
  localparam int TCOST_W       = 16;
  localparam int PRIOR_W       = 16;
  localparam int SUM_W         = 21;
  localparam int CNT_W         = 24;
  localparam int CFG_IDX_W     = 1;
  localparam int ANSWERS       = 3;
  // Queue between front and back; a power of two so the pointers wrap
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic {
    OP_TABLE = 1'b0,
    OP_VOTE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ANS_YES     = 2'd0,
    ANS_NO      = 2'd1,
    ANS_ABSENT  = 2'd2,
    ANS_INVALID = 2'd3
  } answer_t;

  typedef enum logic {
    CLS_DEM = 1'b0,
    CLS_REP = 1'b1
  } class_t;

  typedef enum logic {
    CFG_PRIOR_DEM = 1'b0,
    CFG_PRIOR_REP = 1'b1
  } cfg_idx_t;

  // Control that travels with one vote from front to back
  typedef struct packed {
    logic add_en;
    logic last;
    logic bad;
    logic true_class;
  } vote_ctl_t;

  localparam int CTL_W = $bits(vote_ctl_t);

endpackage

FILE: rtl/nbbv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nbbv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/nbbv_front.sv
// Front end: accepts requests, writes the cost tables, tracks vote position
// and record flags, and issues the cost reads. Depends on nbbv_pkg.
module nbbv_front #(
  parameter int MAX_ATTRS = 16,
  parameter int COST_BITS = 16,
  parameter int ADDR_W    = 6,
  parameter int QCNT_W    = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [3:0]                    in_table_attr,
  input  logic                          in_table_class,
  input  logic [1:0]                    in_table_answer,
  input  logic [nbbv_pkg::TCOST_W-1:0]  in_table_cost,
  input  logic [1:0]                    in_vote_answer,
  input  logic                          in_true_class,
  input  logic                          in_last_vote,
  input  logic [QCNT_W-1:0]             q_count,
  output logic                          ram_we_dem,
  output logic                          ram_we_rep,
  output logic [ADDR_W-1:0]             ram_waddr,
  output logic [COST_BITS-1:0]          ram_wdata,
  output logic [ADDR_W-1:0]             ram_raddr,
  output logic                          push,
  output nbbv_pkg::vote_ctl_t           push_ctl
);
  import nbbv_pkg::*;

  localparam int POS_W = $clog2(MAX_ATTRS + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             bad_r, bad_nxt;
  logic             rd_valid_r, rd_valid_nxt;
  vote_ctl_t        rd_ctl_r, rd_ctl_nxt;

  logic        accept, is_vote, vote_acc, wr_ok;
  logic        pos_full, ans_bad, bad_now;
  logic [31:0] rd_slot, wr_slot;

  // Hold off while queue plus the read in flight could fill the queue
  assign in_stall = (int'(q_count) + int'(rd_valid_r)) >= QUEUE_DEPTH;
  assign accept   = in_valid && !in_stall;
  assign is_vote  = (in_op == OP_VOTE);
  assign vote_acc = accept && is_vote;

  assign pos_full = int'(pos_r) >= MAX_ATTRS;
  assign ans_bad  = (in_vote_answer == ANS_INVALID);
  assign bad_now  = bad_r || pos_full || ans_bad;

  // Table write: drop bad answers and attributes out of range
  assign wr_ok      = accept && !is_vote && (in_table_answer != ANS_INVALID) &&
                      (int'(in_table_attr) < MAX_ATTRS);
  assign wr_slot    = 32'(in_table_attr) * 32'd3 + 32'(in_table_answer);
  assign ram_waddr  = wr_slot[ADDR_W-1:0];
  assign ram_wdata  = COST_BITS'(in_table_cost);
  assign ram_we_dem = wr_ok && (in_table_class == CLS_DEM);
  assign ram_we_rep = wr_ok && (in_table_class == CLS_REP);

  // Read both class costs of this position and answer
  assign rd_slot   = 32'(pos_r) * 32'd3 + 32'(in_vote_answer);
  assign ram_raddr = rd_slot[ADDR_W-1:0];

  // Advance position and record flag, stage vote control
  always_comb begin
    pos_nxt      = pos_r;
    bad_nxt      = bad_r;
    rd_valid_nxt = vote_acc;
    rd_ctl_nxt   = rd_ctl_r;
    if (vote_acc) begin
      rd_ctl_nxt.add_en     = !(pos_full || ans_bad);
      rd_ctl_nxt.last       = in_last_vote;
      rd_ctl_nxt.bad        = bad_now;
      rd_ctl_nxt.true_class = in_true_class;
      if (in_last_vote) begin
        pos_nxt = '0;
        bad_nxt = 1'b0;
      end else begin
        bad_nxt = bad_now;
        if (!pos_full) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      bad_r      <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      bad_r      <= bad_nxt;
      rd_valid_r <= rd_valid_nxt;
    end
    rd_ctl_r <= rd_ctl_nxt;
  end

  // Push once read data is back
  assign push     = rd_valid_r;
  assign push_ctl = rd_ctl_r;

endmodule

FILE: rtl/nbbv_queue.sv
// Small register FIFO between front and back of the vote classifier.
// No dependencies; depth must be a power of two.
module nbbv_queue #(
  parameter int W     = 36,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               push_data,
  input  logic                       pop,
  output logic                       q_valid,
  output logic [W-1:0]               q_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_B = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_B-1:0] count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign count   = count_r;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_B'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CNT_B'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/nbbv_back.sv
// Back end: accumulates class costs, adds priors on the last vote, picks the
// class, scores it and holds the result request. Depends on nbbv_pkg.
module nbbv_back #(
  parameter int COST_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  nbbv_pkg::vote_ctl_t           q_ctl,
  input  logic [COST_BITS-1:0]          q_dem_cost,
  input  logic [COST_BITS-1:0]          q_rep_cost,
  output logic                          pop,
  input  logic [nbbv_pkg::PRIOR_W-1:0]  prior_dem,
  input  logic [nbbv_pkg::PRIOR_W-1:0]  prior_rep,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_predicted_class,
  output logic                          out_matched,
  output logic                          out_record_invalid,
  output logic [nbbv_pkg::CNT_W-1:0]    out_correct_total,
  output logic [nbbv_pkg::CNT_W-1:0]    out_incorrect_total
);
  import nbbv_pkg::*;

  localparam int ACC_W = ((COST_BITS > SUM_W) ? COST_BITS : SUM_W) + 1;
  localparam int TOT_W = ((PRIOR_W > SUM_W) ? PRIOR_W : SUM_W) + 1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [COST_BITS-1:0] b);
    logic [ACC_W-1:0] s;
    s = ACC_W'(a) + ACC_W'(b);
    if (s > ACC_W'(SUM_MAX)) begin
      return SUM_MAX;
    end
    return SUM_W'(s);
  endfunction

  logic [SUM_W-1:0] dem_r, dem_nxt, rep_r, rep_nxt;
  logic [SUM_W-1:0] dem_add, rep_add;
  logic             fin_valid_r, fin_valid_nxt;
  logic [SUM_W-1:0] fin_dem_r, fin_rep_r;
  logic             fin_bad_r, fin_true_r;
  logic             out_valid_r, out_valid_nxt;
  logic             pred_r, match_r, inv_r;
  logic [CNT_W-1:0] correct_r, correct_nxt, incorrect_r, incorrect_nxt;

  logic             out_free, fin_free, fin_adv;
  logic [TOT_W-1:0] dem_tot, rep_tot;
  logic             pred, match;

  assign out_free = !out_valid_r || !out_stall;
  assign fin_adv  = fin_valid_r && out_free;
  assign fin_free = !fin_valid_r || out_free;
  assign pop      = q_valid && fin_free;

  // Accumulate class costs with saturation
  assign dem_add = q_ctl.add_en ? sat_add(dem_r, q_dem_cost) : dem_r;
  assign rep_add = q_ctl.add_en ? sat_add(rep_r, q_rep_cost) : rep_r;

  always_comb begin
    dem_nxt       = dem_r;
    rep_nxt       = rep_r;
    fin_valid_nxt = fin_adv ? 1'b0 : fin_valid_r;
    if (pop) begin
      if (q_ctl.last) begin
        dem_nxt       = '0;
        rep_nxt       = '0;
        fin_valid_nxt = 1'b1;
      end else begin
        dem_nxt = dem_add;
        rep_nxt = rep_add;
      end
    end
  end

  // Add priors, pick republican only on a strictly higher democrat cost
  assign dem_tot = TOT_W'(fin_dem_r) + TOT_W'(prior_dem);
  assign rep_tot = TOT_W'(fin_rep_r) + TOT_W'(prior_rep);
  assign pred    = !fin_bad_r && (dem_tot > rep_tot);
  assign match   = !fin_bad_r && (pred == fin_true_r);

  // Score the record; a flagged record leaves both counters alone
  always_comb begin
    correct_nxt   = correct_r;
    incorrect_nxt = incorrect_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (fin_adv) begin
      out_valid_nxt = 1'b1;
      if (!fin_bad_r) begin
        if (match) begin
          if (!(&correct_r)) begin
            correct_nxt = correct_r + CNT_W'(1);
          end
        end else begin
          if (!(&incorrect_r)) begin
            incorrect_nxt = incorrect_r + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dem_r       <= '0;
      rep_r       <= '0;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      correct_r   <= '0;
      incorrect_r <= '0;
    end else begin
      dem_r       <= dem_nxt;
      rep_r       <= rep_nxt;
      fin_valid_r <= fin_valid_nxt;
      out_valid_r <= out_valid_nxt;
      correct_r   <= correct_nxt;
      incorrect_r <= incorrect_nxt;
    end
    if (pop && q_ctl.last) begin
      fin_dem_r  <= dem_add;
      fin_rep_r  <= rep_add;
      fin_bad_r  <= q_ctl.bad;
      fin_true_r <= q_ctl.true_class;
    end
    if (fin_adv) begin
      pred_r  <= pred;
      match_r <= match;
      inv_r   <= fin_bad_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_class = pred_r;
  assign out_matched         = match_r;
  assign out_record_invalid  = inv_r;
  assign out_correct_total   = correct_r;
  assign out_incorrect_total = incorrect_r;

endmodule

FILE: rtl/naive_bayes_binary_vote_classifier.sv
// Two-class naive Bayes vote classifier, top level.
// Throughput: one request per cycle unless stalled, table writes and votes alike.
// After its last vote is accepted, a result passes the cost RAM read (at the
// accepting edge), the queue write, the accumulate and the prior add and compare.
// Reset clears positions, sums, counters, priors and queue; the cost tables
// are not cleared and must be written before votes read them.
module naive_bayes_binary_vote_classifier #(
  parameter int MAX_ATTRS = nbbv_pkg::MAX_ATTRS_DEF,
  parameter int COST_BITS = nbbv_pkg::COST_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [3:0]                    in_table_attr,
  input  logic                          in_table_class,
  input  logic [1:0]                    in_table_answer,
  input  logic [nbbv_pkg::TCOST_W-1:0]  in_table_cost,
  input  logic [1:0]                    in_vote_answer,
  input  logic                          in_true_class,
  input  logic                          in_last_vote,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_predicted_class,
  output logic                          out_matched,
  output logic                          out_record_invalid,
  output logic [nbbv_pkg::CNT_W-1:0]    out_correct_total,
  output logic [nbbv_pkg::CNT_W-1:0]    out_incorrect_total,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nbbv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nbbv_pkg::PRIOR_W-1:0]  cfg_data
);
  import nbbv_pkg::*;

  localparam int DEPTH  = MAX_ATTRS * ANSWERS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QW     = CTL_W + 2 * COST_BITS;

  logic [PRIOR_W-1:0]   prior_dem_r, prior_dem_nxt, prior_rep_r, prior_rep_nxt;
  logic                 ram_we_dem, ram_we_rep;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [COST_BITS-1:0] ram_wdata, dem_rdata, rep_rdata;
  logic                 push, pop, q_valid;
  vote_ctl_t            push_ctl, q_ctl;
  logic [QW-1:0]        q_data;
  logic [QCNT_W-1:0]    q_count;

  // Take prior writes at any time
  assign cfg_ready = 1'b1;

  always_comb begin
    prior_dem_nxt = prior_dem_r;
    prior_rep_nxt = prior_rep_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRIOR_DEM: prior_dem_nxt = cfg_data;
        CFG_PRIOR_REP: prior_rep_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_dem_r <= '0;
      prior_rep_r <= '0;
    end else begin
      prior_dem_r <= prior_dem_nxt;
      prior_rep_r <= prior_rep_nxt;
    end
  end

  nbbv_front #(
    .MAX_ATTRS (MAX_ATTRS),
    .COST_BITS (COST_BITS),
    .ADDR_W    (ADDR_W),
    .QCNT_W    (QCNT_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_table_attr   (in_table_attr),
    .in_table_class  (in_table_class),
    .in_table_answer (in_table_answer),
    .in_table_cost   (in_table_cost),
    .in_vote_answer  (in_vote_answer),
    .in_true_class   (in_true_class),
    .in_last_vote    (in_last_vote),
    .q_count         (q_count),
    .ram_we_dem      (ram_we_dem),
    .ram_we_rep      (ram_we_rep),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .push            (push),
    .push_ctl        (push_ctl)
  );

  // One cost table per class, same address for both
  nbbv_ram #(.WIDTH(COST_BITS), .DEPTH(DEPTH)) u_ram_dem (
    .clk   (clk),
    .we    (ram_we_dem),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (dem_rdata)
  );

  nbbv_ram #(.WIDTH(COST_BITS), .DEPTH(DEPTH)) u_ram_rep (
    .clk   (clk),
    .we    (ram_we_rep),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rep_rdata)
  );

  nbbv_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctl, dem_rdata, rep_rdata}),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .count     (q_count)
  );

  assign q_ctl = vote_ctl_t'(q_data[QW-1 -: CTL_W]);

  nbbv_back #(.COST_BITS(COST_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_ctl               (q_ctl),
    .q_dem_cost          (q_data[2*COST_BITS-1 -: COST_BITS]),
    .q_rep_cost          (q_data[COST_BITS-1:0]),
    .pop                 (pop),
    .prior_dem           (prior_dem_r),
    .prior_rep           (prior_rep_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_predicted_class (out_predicted_class),
    .out_matched         (out_matched),
    .out_record_invalid  (out_record_invalid),
    .out_correct_total   (out_correct_total),
    .out_incorrect_total (out_incorrect_total)
  );

endmodule

FILE: rtl/nbbv_checker.sv
// Port-level checks of the vote classifier's result channel, bound to the top.
// Depends on nbbv_pkg and naive_bayes_binary_vote_classifier.
module nbbv_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_predicted_class,
  input logic                       out_matched,
  input logic                       out_record_invalid,
  input logic [nbbv_pkg::CNT_W-1:0] out_correct_total,
  input logic [nbbv_pkg::CNT_W-1:0] out_incorrect_total
);

  // Stalled result request holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_predicted_class) &&
    $stable(out_matched) && $stable(out_record_invalid))
    else $error("stalled result changed");

  // Flagged record is never scored as a match or a republican pick
  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_invalid |-> !out_matched && !out_predicted_class)
    else $error("flagged record carries a prediction");

  // Counters never fall outside reset
  a_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_correct_total >= $past(out_correct_total)) &&
    (out_incorrect_total >= $past(out_incorrect_total)))
    else $error("counter decreased");

  // Counters move only together with a shown result
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && ((out_correct_total != $past(out_correct_total)) ||
    (out_incorrect_total != $past(out_incorrect_total))) |-> out_valid)
    else $error("counter moved without a result");

endmodule

bind naive_bayes_binary_vote_classifier nbbv_checker u_nbbv_checker (.*);
